// File: sv/fqr_pkg.sv
// ----------------------------------------------------------------------------
// fqr_pkg: shared definitions for the framed query receiver
// Holds the command and register codes, the start bytes, the payload limit,
// the result record and the bytewise CRC-16-CCITT update.
// ----------------------------------------------------------------------------
package fqr_pkg;

    // Item commands
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // Configuration register indexes
    localparam logic REG_OWN_ADDRESS = 1'b0;
    localparam logic REG_RX_ENABLE   = 1'b1;

    localparam int unsigned CFG_DATA_W = 7;

    // Frame start bytes
    localparam logic [7:0] START_SYN = 8'h16;
    localparam logic [7:0] START_DLE = 8'h10;

    // Header positions and payload limit
    localparam logic [7:0] POS_LENGTH  = 8'd0;
    localparam logic [7:0] POS_LENGTH2 = 8'd1;
    localparam logic [7:0] POS_MESSAGE = 8'd2;
    localparam logic [7:0] POS_ADDRESS = 8'd3;
    localparam logic [7:0] POS_COMMAND = 8'd4;
    localparam logic [7:0] HEADER_BYTES = 8'd5;
    localparam int unsigned PAYLOAD_BYTES = 32;

    localparam logic [7:0]  OWN_ADDRESS_RESET = 8'd16;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    typedef struct packed {
        logic       consumed;
        logic       data_valid;
        logic [4:0] data_index;
        logic [7:0] data_byte;
        logic       frame_done;
        logic       frame_crc_ok;
        logic       frame_repeated;
        logic       frame_read;
        logic       frame_has_cmd;
        logic [7:0] frame_command;
        logic [5:0] frame_data_size;
        logic [2:0] frame_msg_id;
    } fqr_result_t;

    // Reflected CRC-16-CCITT, one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: sv/fqr_in_stage.sv
// ----------------------------------------------------------------------------
// fqr_in_stage: input register
// Captures one transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module fqr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       item_valid,
    output logic [1:0] item_cmd,
    output logic [7:0] item_byte
);
    logic       valid_reg;
    logic [1:0] cmd_reg;
    logic [7:0] byte_reg;

    // stall only while a held item cannot move on
    assign in_stall = valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg  <= cmd;
            byte_reg <= rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_cmd   = cmd_reg;
    assign item_byte  = byte_reg;
endmodule

// File: sv/fqr_core.sv
// ----------------------------------------------------------------------------
// fqr_core: frame parser
// Holds frame state and configuration, and works out one result per item.
// ----------------------------------------------------------------------------
module fqr_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [fqr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          step,
    input  logic [1:0]                    item_cmd,
    input  logic [7:0]                    item_byte,
    output fqr_pkg::fqr_result_t          result
);
    import fqr_pkg::*;

    logic [6:0]  own_address_reg;
    logic        receiver_enable_reg;

    logic        tracking_reg, tracking_next;
    logic        ignore_reg, ignore_next;
    logic        repeat_reg, repeat_next;
    logic        read_reg, read_next;
    logic        cmd_flag_reg, cmd_flag_next;
    logic        pending_reg, pending_next;
    logic [7:0]  position_reg, position_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  msg_id_reg, msg_id_next;
    logic        last_valid_reg, last_valid_next;
    logic [2:0]  last_id_reg, last_id_next;
    logic [7:0]  command_reg, command_next;

    logic [7:0]  v;
    logic [7:0]  data_idx;
    logic        crc_ok;
    logic        at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg     <= OWN_ADDRESS_RESET[6:0];
            receiver_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OWN_ADDRESS: own_address_reg     <= cfg_data;
                REG_RX_ENABLE:   receiver_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        tracking_next   = tracking_reg;
        ignore_next     = ignore_reg;
        repeat_next     = repeat_reg;
        read_next       = read_reg;
        cmd_flag_next   = cmd_flag_reg;
        pending_next    = pending_reg;
        position_next   = position_reg;
        length_next     = length_reg;
        crc_next        = crc_reg;
        msg_id_next     = msg_id_reg;
        last_valid_next = last_valid_reg;
        last_id_next    = last_id_reg;
        command_next    = command_reg;
        result          = '0;

        // invert bytes at or beyond the length, i.e. the CRC trailer
        v        = (position_reg >= length_reg) ? ~item_byte : item_byte;
        data_idx = position_reg - HEADER_BYTES;
        crc_ok   = (crc_byte(crc_reg, v) == 16'h0000);
        at_end   = ({1'b0, position_reg} == ({1'b0, length_reg} + 9'd1));

        case (item_cmd)
            CMD_TIMEOUT:
            begin
                tracking_next = 1'b0;
                ignore_next   = 1'b0;
                repeat_next   = 1'b0;
                read_next     = 1'b0;
                cmd_flag_next = 1'b0;
            end
            CMD_RELEASE:
            begin
                pending_next = 1'b0;
            end
            CMD_BYTE:
            begin
                if (receiver_enable_reg && !tracking_reg)
                begin
                    if (item_byte inside {START_SYN, START_DLE})
                    begin
                        result.consumed = 1'b1;
                        tracking_next   = 1'b1;
                        repeat_next     = 1'b0;
                        read_next       = 1'b0;
                        cmd_flag_next   = 1'b0;
                        ignore_next     = (item_byte == START_SYN) || pending_reg;
                        position_next   = 8'd0;
                        length_next     = 8'hFF;
                        crc_next        = CRC_INIT;
                    end
                end
                else if (receiver_enable_reg)
                begin
                    result.consumed = 1'b1;
                    crc_next        = crc_byte(crc_reg, v);
                    position_next   = position_reg + 8'd1;
                    if (position_reg == POS_LENGTH)
                    begin
                        length_next = v;
                        if (v > 8'(PAYLOAD_BYTES + 5))
                        begin
                            ignore_next = 1'b1;
                        end
                    end
                    else if (position_reg == POS_LENGTH2)
                    begin
                        // length mismatch: drop the frame
                        if (v != length_reg)
                        begin
                            tracking_next = 1'b0;
                            ignore_next   = 1'b0;
                            repeat_next   = 1'b0;
                            read_next     = 1'b0;
                            cmd_flag_next = 1'b0;
                        end
                    end
                    else if (position_reg == POS_MESSAGE)
                    begin
                        if (v[0])
                        begin
                            ignore_next = 1'b1;
                        end
                        else
                        begin
                            msg_id_next = v[3:1];
                            if (last_valid_reg && (v[3:1] == last_id_reg))
                            begin
                                repeat_next = 1'b1;
                            end
                        end
                    end
                    else if (position_reg == POS_ADDRESS)
                    begin
                        if (v[0])
                        begin
                            read_next         = 1'b1;
                            result.data_valid = 1'b1;
                        end
                        if (v[7:1] != own_address_reg)
                        begin
                            ignore_next = 1'b1;
                        end
                    end
                    else if (position_reg == length_reg)
                    begin
                        // low CRC byte: accumulate only
                    end
                    else if (at_end)
                    begin
                        if (!ignore_reg)
                        begin
                            result.frame_done     = 1'b1;
                            result.frame_crc_ok   = crc_ok;
                            result.frame_repeated = repeat_reg;
                            result.frame_read     = read_reg;
                            result.frame_has_cmd  = cmd_flag_reg;
                            result.frame_command  = command_reg;
                            result.frame_msg_id   = msg_id_reg;
                            if (crc_ok && (length_reg > HEADER_BYTES))
                            begin
                                result.frame_data_size = 6'(length_reg - HEADER_BYTES);
                            end
                            pending_next = 1'b1;
                        end
                        tracking_next   = 1'b0;
                        last_valid_next = 1'b1;
                        last_id_next    = msg_id_reg;
                    end
                    else if (position_reg == POS_COMMAND)
                    begin
                        if (!ignore_reg)
                        begin
                            cmd_flag_next = 1'b1;
                            command_next  = v;
                        end
                    end
                    else if (!ignore_reg && !repeat_reg && (data_idx < 8'(PAYLOAD_BYTES)))
                    begin
                        result.data_valid = 1'b1;
                        result.data_index = data_idx[4:0];
                        result.data_byte  = v;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg   <= 1'b0;
            ignore_reg     <= 1'b0;
            repeat_reg     <= 1'b0;
            read_reg       <= 1'b0;
            cmd_flag_reg   <= 1'b0;
            pending_reg    <= 1'b0;
            position_reg   <= 8'd0;
            length_reg     <= 8'hFF;
            crc_reg        <= 16'h0000;
            msg_id_reg     <= 3'd0;
            last_valid_reg <= 1'b0;
            last_id_reg    <= 3'd0;
            command_reg    <= 8'd0;
        end
        else if (step)
        begin
            tracking_reg   <= tracking_next;
            ignore_reg     <= ignore_next;
            repeat_reg     <= repeat_next;
            read_reg       <= read_next;
            cmd_flag_reg   <= cmd_flag_next;
            pending_reg    <= pending_next;
            position_reg   <= position_next;
            length_reg     <= length_next;
            crc_reg        <= crc_next;
            msg_id_reg     <= msg_id_next;
            last_valid_reg <= last_valid_next;
            last_id_reg    <= last_id_next;
            command_reg    <= command_next;
        end
    end

    a_done_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.frame_done |=> pending_reg)
        else $error("completed frame did not leave a query pending");

    a_timeout_stops: assert property (@(posedge clk) disable iff (!rst_n)
        step && (item_cmd == CMD_TIMEOUT) |=> !tracking_reg && !ignore_reg)
        else $error("timeout did not drop the frame");

    a_data_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        step && (result.data_valid || result.frame_done) |-> result.consumed)
        else $error("payload or frame end reported for a byte not consumed");

endmodule

// File: sv/fqr_out_stage.sv
// ----------------------------------------------------------------------------
// fqr_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module fqr_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  fqr_pkg::fqr_result_t result_in,
    output logic                 open,
    input  logic                 out_stall,
    output logic                 out_valid,
    output fqr_pkg::fqr_result_t result_out
);
    import fqr_pkg::*;

    logic        valid_reg;
    fqr_result_t result_reg;

    // room for a new result when empty or when the held one leaves now
    assign open = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;
endmodule

// File: sv/framed_query_receiver.sv
// ----------------------------------------------------------------------------
// framed_query_receiver: serial frame receiver with header checks and CRC
// Parses DLE-started frames byte by byte and reports payload bytes and frame end.
// ----------------------------------------------------------------------------
// One item enters per clock cycle while in_stall is low, and every item gives
// exactly one result, which passes through the input register and then the
// result register. The rate of one item per cycle is set by the frame state
// update, which runs the bytewise CRC-16-CCITT step and the header compares
// combinationally between the input register and the result register. A new
// item is taken while a finished result still waits downstream; the input
// side stalls only when both registers are full and out_stall is high.
// Each item is a received byte (cmd 0), a line timeout that drops the current
// frame (cmd 1), or a release that clears a pending query (cmd 2). A frame
// opens with DLE; SYN frames and frames opening while a query is pending are
// followed but report no payload bytes and no frame end; only the read marker
// at the address byte still shows. The CRC trailer is inverted before it is
// checked. Write own_address (index 0) and receiver_enable (index 1) only
// while no transfer is in flight.
// ----------------------------------------------------------------------------
module framed_query_receiver (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [fqr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           consumed,
    output logic                           data_valid,
    output logic [4:0]                     data_index,
    output logic [7:0]                     data_byte,
    output logic                           frame_done,
    output logic                           frame_crc_ok,
    output logic                           frame_repeated,
    output logic                           frame_read,
    output logic                           frame_has_cmd,
    output logic [7:0]                     frame_command,
    output logic [5:0]                     frame_data_size,
    output logic [2:0]                     frame_msg_id
);
    import fqr_pkg::*;

    logic        item_valid;
    logic [1:0]  item_cmd;
    logic [7:0]  item_byte;
    logic        out_open;
    logic        advance;
    fqr_result_t core_result;
    fqr_result_t held_result;

    // advance the held item into the core whenever the result register has room
    assign advance = item_valid && out_open;

    fqr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .rx_byte    (rx_byte),
        .take       (advance),
        .item_valid (item_valid),
        .item_cmd   (item_cmd),
        .item_byte  (item_byte)
    );

    fqr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .item_cmd  (item_cmd),
        .item_byte (item_byte),
        .result    (core_result)
    );

    fqr_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (core_result),
        .open       (out_open),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .result_out (held_result)
    );

    // unpack the held result onto the field ports
    assign consumed        = held_result.consumed;
    assign data_valid      = held_result.data_valid;
    assign data_index      = held_result.data_index;
    assign data_byte       = held_result.data_byte;
    assign frame_done      = held_result.frame_done;
    assign frame_crc_ok    = held_result.frame_crc_ok;
    assign frame_repeated  = held_result.frame_repeated;
    assign frame_read      = held_result.frame_read;
    assign frame_has_cmd   = held_result.frame_has_cmd;
    assign frame_command   = held_result.frame_command;
    assign frame_data_size = held_result.frame_data_size;
    assign frame_msg_id    = held_result.frame_msg_id;

endmodule
